/* design/atil_pkg.sv */
// ----------------------------------------------------------------------------
// atil_pkg
// Shared constants, codes and the mask-to-frame table of the autotile index
// lookup unit.
// ----------------------------------------------------------------------------
package atil_pkg;

    // Field widths
    localparam int unsigned REG_W        = 8;   // configuration register width
    localparam int unsigned CFG_IDX_W    = 8;   // configuration index width
    localparam int unsigned COORD_W      = 16;  // tile coordinate width
    localparam int unsigned TILE_INDEX_W = 4;   // result width
    localparam int unsigned ROW_W        = 5;   // page row of an in-map cell
    localparam int unsigned IDX_W        = 13;  // byte index, 31 * 255 + 255 fits

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_FRAMES    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_DATA_BYTES = 8'd3;

    // Configuration reset values
    localparam logic [REG_W-1:0] RST_TILE_FRAMES    = 8'd11;
    localparam logic [REG_W-1:0] RST_MAP_WIDTH      = 8'd16;
    localparam logic [REG_W-1:0] RST_MAP_HEIGHT     = 8'd8;
    localparam logic [REG_W-1:0] RST_MAP_DATA_BYTES = 8'd0;

    // Tileset frame counts that select a mapping
    localparam logic [REG_W-1:0] FRAMES_TWO    = 8'd2;
    localparam logic [REG_W-1:0] FRAMES_ELEVEN = 8'd11;

    // Cells examined per query
    localparam int unsigned CELLS = 5;
    typedef enum logic [2:0] {
        CELL_CENTER = 3'd0,
        CELL_LEFT   = 3'd1,
        CELL_UP     = 3'd2,
        CELL_RIGHT  = 3'd3,
        CELL_DOWN   = 3'd4
    } t_cell;

    typedef logic [TILE_INDEX_W-1:0] t_tile_index;

    localparam t_tile_index TILE_ZERO = 4'd0;
    localparam t_tile_index TILE_ONE  = 4'd1;
    localparam logic [3:0]  MASK_ALL  = 4'hF;

    // Eleven-frame mapping; mask bit 3 left, 2 up, 1 right, 0 down
    localparam t_tile_index FRAMES11_TABLE [16] = '{
        4'd10, 4'd10, 4'd10, 4'd1, 4'd10, 4'd10, 4'd7, 4'd4,
        4'd10, 4'd3,  4'd10, 4'd2, 4'd9,  4'd6,  4'd8, 4'd5
    };

endpackage

/* design/autotile_index_lookup_unit.sv */
// ----------------------------------------------------------------------------
// autotile_index_lookup_unit
// Four-neighbor bitmask autotile lookup over a page-packed 1-bit map.
// ----------------------------------------------------------------------------
// One item (a map byte write or a tile query) is taken every cycle that o_stall
// is low; a query returns its tile index from the stage 5 register, writes
// return nothing. The five-stage pipeline is: register the item, bound-check
// the five cells, form byte indexes (one small multiply per cell), read the
// map (five copies of the map RAM, one per cell, all written together), and
// map the neighbor mask to a frame index. A write lands in the map when it
// leaves the third stage, so a query right behind it already sees the new
// byte. Stalls hold each occupied stage; empty stages still fill, so input
// transfers continue while a result waits at the output. Map contents are
// not cleared by reset; a query must touch only bytes that were written.
// Configuration writes are taken at any time (ready is always high) but
// belong to idle periods.
module autotile_index_lookup_unit #(
    parameter int unsigned MAP_BYTES = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input items
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_kind,
    input  logic [7:0]                           i_byte_addr,
    input  logic [7:0]                           i_byte_value,
    input  logic signed [atil_pkg::COORD_W-1:0]  i_tile_x,
    input  logic signed [atil_pkg::COORD_W-1:0]  i_tile_y,
    // results
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [atil_pkg::TILE_INDEX_W-1:0]    o_tile_index,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [atil_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [atil_pkg::REG_W-1:0]           i_cfg_data
);

    import atil_pkg::*;

    localparam int unsigned AW = $clog2(MAP_BYTES);

    // Configuration registers
    logic [REG_W-1:0] r_tile_frames;
    logic [REG_W-1:0] r_map_width;
    logic [REG_W-1:0] r_map_height;
    logic [REG_W-1:0] r_map_data_bytes;

    // Stage handshake
    logic ready1, ready2, ready3, ready4, ready5;

    // Stage 1: registered item
    logic                       r1_valid;
    logic                       r1_kind;
    logic [7:0]                 r1_addr;
    logic [7:0]                 r1_value;
    logic signed [COORD_W-1:0]  r1_x;
    logic signed [COORD_W-1:0]  r1_y;

    // Stage 2: bound check per cell
    logic                       r2_valid;
    logic                       r2_kind;
    logic [7:0]                 r2_addr;
    logic [7:0]                 r2_value;
    logic                       r2_out  [CELLS];
    logic [7:0]                 r2_col  [CELLS];
    logic [ROW_W-1:0]           r2_row  [CELLS];
    logic [2:0]                 r2_bit  [CELLS];

    // Stage 3: byte index per cell
    logic                       r3_valid;
    logic                       r3_kind;
    logic [7:0]                 r3_addr;
    logic [7:0]                 r3_value;
    logic                       r3_out  [CELLS];
    logic [IDX_W-1:0]           r3_idx  [CELLS];
    logic [2:0]                 r3_bit  [CELLS];

    // Stage 4: forced-solid flags plus RAM read data
    logic                       r4_valid;
    logic                       r4_kind;
    logic                       r4_force [CELLS];
    logic [2:0]                 r4_bit   [CELLS];
    logic [7:0]                 ram_q    [CELLS];

    // Stage 5: output register
    logic                       r5_valid;
    t_tile_index                r5_index;

    // Combinational helpers
    logic signed [COORD_W:0]    cx [CELLS];
    logic signed [COORD_W:0]    cy [CELLS];
    logic                       n2_out [CELLS];
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr_ext;
    logic [CELLS-1:0]           solid;
    logic [3:0]                 mask;
    t_tile_index                n5_index;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_frames    <= RST_TILE_FRAMES;
            r_map_width      <= RST_MAP_WIDTH;
            r_map_height     <= RST_MAP_HEIGHT;
            r_map_data_bytes <= RST_MAP_DATA_BYTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TILE_FRAMES:    r_tile_frames    <= i_cfg_data;
                CFG_MAP_WIDTH:      r_map_width      <= i_cfg_data;
                CFG_MAP_HEIGHT:     r_map_height     <= i_cfg_data;
                CFG_MAP_DATA_BYTES: r_map_data_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow: a stage loads when it is empty or its content moves on
    // ------------------------------------------------------------------
    assign ready5  = !r5_valid || !i_stall;
    assign ready4  = !r4_valid || ready5;
    assign ready3  = !r3_valid || ready4;
    assign ready2  = !r2_valid || ready3;
    assign ready1  = !r1_valid || ready2;
    assign o_stall = !ready1;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            if (ready1) r1_valid <= i_valid;
            if (ready2) r2_valid <= r1_valid;
            if (ready3) r3_valid <= r2_valid;
            if (ready4) r4_valid <= r3_valid;
            // writes end at stage 4; only queries reach the output
            if (ready5) r5_valid <= r4_valid && (r4_kind == KIND_QUERY);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the item
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r1_kind  <= i_kind;
            r1_addr  <= i_byte_addr;
            r1_value <= i_byte_value;
            r1_x     <= i_tile_x;
            r1_y     <= i_tile_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: neighbor coordinates and map bounds
    // ------------------------------------------------------------------
    always_comb begin
        cx[CELL_CENTER] = {r1_x[COORD_W-1], r1_x};
        cy[CELL_CENTER] = {r1_y[COORD_W-1], r1_y};
        cx[CELL_LEFT]   = cx[CELL_CENTER] - 17'sd1;
        cy[CELL_LEFT]   = cy[CELL_CENTER];
        cx[CELL_UP]     = cx[CELL_CENTER];
        cy[CELL_UP]     = cy[CELL_CENTER] - 17'sd1;
        cx[CELL_RIGHT]  = cx[CELL_CENTER] + 17'sd1;
        cy[CELL_RIGHT]  = cy[CELL_CENTER];
        cx[CELL_DOWN]   = cx[CELL_CENTER];
        cy[CELL_DOWN]   = cy[CELL_CENTER] + 17'sd1;
        for (int c = 0; c < CELLS; c++) begin
            // inside only when non-negative, below 256 and below the size
            n2_out[c] = !((cx[c][COORD_W:8] == '0) && (cx[c][7:0] < r_map_width) &&
                          (cy[c][COORD_W:8] == '0) && (cy[c][7:0] < r_map_height));
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r2_kind  <= r1_kind;
            r2_addr  <= r1_addr;
            r2_value <= r1_value;
            for (int c = 0; c < CELLS; c++) begin
                r2_out[c] <= n2_out[c];
                r2_col[c] <= cx[c][7:0];
                r2_row[c] <= cy[c][7:3];
                r2_bit[c] <= cy[c][2:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: byte index = column + page * width
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r3_kind  <= r2_kind;
            r3_addr  <= r2_addr;
            r3_value <= r2_value;
            for (int c = 0; c < CELLS; c++) begin
                r3_out[c] <= r2_out[c];
                r3_bit[c] <= r2_bit[c];
                r3_idx[c] <= IDX_W'(r2_row[c]) * IDX_W'(r_map_width) + IDX_W'(r2_col[c]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: map read, write commit, solid forcing
    // ------------------------------------------------------------------
    assign wr_addr_ext = IDX_W'(r3_addr);
    assign wr_en = r3_valid && (r3_kind == KIND_WRITE) && ready4 &&
                   (32'(r3_addr) < MAP_BYTES);

    for (genvar g = 0; g < CELLS; g++) begin : g_map
        atil_ram #(
            .WIDTH (8),
            .DEPTH (MAP_BYTES)
        ) u_map_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en),
            .i_waddr (wr_addr_ext[AW-1:0]),
            .i_wdata (r3_value),
            .i_re    (ready4),
            .i_raddr (r3_idx[g][AW-1:0]),
            .o_rdata (ram_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (ready4) begin
            r4_kind <= r3_kind;
            for (int c = 0; c < CELLS; c++) begin
                r4_bit[c]   <= r3_bit[c];
                r4_force[c] <= r3_out[c] ||
                               (r3_idx[c] >= IDX_W'(r_map_data_bytes)) ||
                               (32'(r3_idx[c]) >= MAP_BYTES);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: neighbor mask to frame index
    // ------------------------------------------------------------------
    always_comb begin
        for (int c = 0; c < CELLS; c++) begin
            solid[c] = r4_force[c] || ram_q[c][r4_bit[c]];
        end
        mask = {solid[CELL_LEFT], solid[CELL_UP], solid[CELL_RIGHT], solid[CELL_DOWN]};
        if (!solid[CELL_CENTER]) begin
            n5_index = TILE_ZERO;
        end else if (r_tile_frames == FRAMES_TWO) begin
            n5_index = (mask == MASK_ALL) ? TILE_ZERO : TILE_ONE;
        end else if (r_tile_frames == FRAMES_ELEVEN) begin
            n5_index = FRAMES11_TABLE[mask];
        end else begin
            n5_index = TILE_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready5) begin
            r5_index <= n5_index;
        end
    end

    assign o_valid      = r5_valid;
    assign o_tile_index = r5_index;

endmodule

/* design/atil_ram.sv */
// ----------------------------------------------------------------------------
// atil_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module atil_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* bench/autotile_index_lookup_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// autotile_index_lookup_unit_tb
// Self-checking bench for the four-neighbor autotile index lookup unit.
// ----------------------------------------------------------------------------
// The whole map store is loaded first, so no query ever reads a byte that
// was never written. A short directed sequence follows, then random phases,
// each with its own map geometry and frame count. A tracker class mirrors the
// map and the registers and predicts the tile index of every accepted query.
// Both channels idle at random. One phase holds the result side off for a
// long stretch while items keep coming. Another pauses the item side until
// every pending result has arrived. Registers change only while the unit is
// idle.
// ----------------------------------------------------------------------------
module autotile_index_lookup_unit_tb;
    import atil_pkg::*;

    localparam int MAP_BYTES        = 256;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int SETTLE_CYCLES    = 12;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int PHASE_ITEMS      = 40;
    localparam int REPORT_LIMIT     = 10;

    typedef enum int {PHASE_PLAIN, PHASE_SQUEEZE, PHASE_PAUSE} t_phase_mode;

    typedef struct {
        logic                      kind;
        logic [7:0]                addr;
        logic [7:0]                value;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_map_item;

    // Mirror of the map and registers; predicts and checks tile indexes
    class t_tile_index_tracker;
        logic [7:0]       map_bytes [MAP_BYTES];
        logic [REG_W-1:0] frames;
        logic [REG_W-1:0] width;
        logic [REG_W-1:0] height;
        logic [REG_W-1:0] loaded;
        t_tile_index      expected_index [$];
        int               fail_count;

        function new();
            frames     = RST_TILE_FRAMES;
            width      = RST_MAP_WIDTH;
            height     = RST_MAP_HEIGHT;
            loaded     = RST_MAP_DATA_BYTES;
            fail_count = 0;
            foreach (map_bytes[i]) map_bytes[i] = 8'h00;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
            case (idx)
                CFG_TILE_FRAMES:    frames = data;
                CFG_MAP_WIDTH:      width  = data;
                CFG_MAP_HEIGHT:     height = data;
                CFG_MAP_DATA_BYTES: loaded = data;
                default: ;
            endcase
        endfunction

        // Off-map cells and bytes past the loaded length read as solid
        function bit cell_is_solid(int x, int y);
            int idx;
            if (x < 0 || y < 0) return 1'b1;
            if (x >= int'(width) || y >= int'(height)) return 1'b1;
            idx = x + (y >>> 3) * int'(width);
            if (idx >= int'(loaded) || idx >= MAP_BYTES) return 1'b1;
            return map_bytes[idx][y & 7];
        endfunction

        function t_tile_index eleven_frame_index(logic [3:0] mask);
            case (mask)
                4'd3:    return 4'd1;
                4'd11:   return 4'd2;
                4'd9:    return 4'd3;
                4'd7:    return 4'd4;
                4'd15:   return 4'd5;
                4'd13:   return 4'd6;
                4'd6:    return 4'd7;
                4'd14:   return 4'd8;
                4'd12:   return 4'd9;
                default: return 4'd10;
            endcase
        endfunction

        // mask: left, up, right, down from msb to lsb
        function t_tile_index predict(int x, int y);
            logic [3:0] mask;
            if (!cell_is_solid(x, y)) return TILE_ZERO;
            mask = {cell_is_solid(x - 1, y), cell_is_solid(x, y - 1),
                    cell_is_solid(x + 1, y), cell_is_solid(x, y + 1)};
            if (frames == FRAMES_TWO) return (mask == MASK_ALL) ? TILE_ZERO : TILE_ONE;
            if (frames == FRAMES_ELEVEN) return eleven_frame_index(mask);
            return TILE_ZERO;
        endfunction

        function void note_item(logic kind, logic [7:0] addr, logic [7:0] value,
                                logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y);
            if (kind == KIND_WRITE) map_bytes[addr] = value;
            else expected_index.push_back(predict(int'(x), int'(y)));
        endfunction

        function void check_index(t_tile_index actual);
            t_tile_index want;
            if (expected_index.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("tile index %0d arrived with no query pending", actual);
                return;
            end
            want = expected_index.pop_front();
            if (actual !== want) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("tile index mismatch: expected %0d, actual %0d", want, actual);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic                      i_kind;
    logic [7:0]                i_byte_addr;
    logic [7:0]                i_byte_value;
    logic signed [COORD_W-1:0] i_tile_x;
    logic signed [COORD_W-1:0] i_tile_y;
    logic                      o_valid;
    logic                      i_stall;
    logic [TILE_INDEX_W-1:0]   o_tile_index;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [REG_W-1:0]          i_cfg_data;

    t_tile_index_tracker tracker;
    bit                  gap_free      = 1'b0;
    bit                  drain_sink    = 1'b0;
    bit                  long_hold_req = 1'b0;
    int                  quiet_cycles  = 0;

    autotile_index_lookup_unit #(
        .MAP_BYTES (MAP_BYTES)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_byte_addr  (i_byte_addr),
        .i_byte_value (i_byte_value),
        .i_tile_x     (i_tile_x),
        .i_tile_y     (i_tile_y),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tile_index (o_tile_index),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                tracker.note_item(i_kind, i_byte_addr, i_byte_value, i_tile_x, i_tile_y);
            if (o_valid && !i_stall)
                tracker.check_index(o_tile_index);
            if (i_cfg_valid && o_cfg_ready)
                tracker.write_reg(i_cfg_index, i_cfg_data);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Result side stall: random runs, a long hold on request, none while draining
    initial begin
        int unsigned r;
        int unsigned len;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            r = $urandom_range(0, 99);
            if (drain_sink) begin
                i_stall <= 1'b0;
                len = 1;
            end else if (long_hold_req) begin
                i_stall <= 1'b1;
                len = LONG_HOLD_CYCLES;
                long_hold_req = 1'b0;
            end else if (r < 10) begin
                i_stall <= 1'b0;
                len = $urandom_range(20, 60);
            end else if (r < 55) begin
                i_stall <= 1'b0;
                len = $urandom_range(1, 8);
            end else if (r < 93) begin
                i_stall <= 1'b1;
                len = $urandom_range(1, 4);
            end else begin
                i_stall <= 1'b1;
                len = $urandom_range(12, 30);
            end
            repeat (len) @(posedge i_clk);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gap_free || r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    function automatic t_map_item make_write(int addr, int value);
        t_map_item it;
        it.kind  = KIND_WRITE;
        it.addr  = addr[7:0];
        it.value = value[7:0];
        it.x     = 16'($urandom);
        it.y     = 16'($urandom);
        return it;
    endfunction

    function automatic t_map_item make_query(int x, int y);
        t_map_item it;
        it.kind  = KIND_QUERY;
        it.addr  = 8'($urandom);
        it.value = 8'($urandom);
        it.x     = x[COORD_W-1:0];
        it.y     = y[COORD_W-1:0];
        return it;
    endfunction

    function automatic logic signed [COORD_W-1:0] coord_edge();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh8001;
            2:       return 16'shFFFF;
            3:       return 16'sh0000;
            4:       return 16'sh7FFE;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // Mostly queries near the map edge, some far off, some map writes
    function automatic t_map_item random_item(int unsigned w, int unsigned h,
                                              int unsigned loaded);
        t_map_item   it;
        int unsigned r;
        it.kind  = KIND_QUERY;
        it.addr  = 8'($urandom);
        it.value = 8'($urandom);
        it.x     = 16'($urandom);
        it.y     = 16'($urandom);
        r = $urandom_range(0, 99);
        if (r < 25) begin
            it.kind = KIND_WRITE;
            if (loaded > 0 && $urandom_range(0, 1))
                it.addr = 8'($urandom_range(0, loaded - 1));
        end else if (r < 80) begin
            it.x = 16'($urandom_range(0, w + 3) - 2);
            it.y = 16'($urandom_range(0, h + 3) - 2);
        end else if (r < 90) begin
            it.x = coord_edge();
            it.y = $urandom_range(0, 1) ? coord_edge() : 16'($urandom_range(0, h + 1));
        end
        return it;
    endfunction

    // Offer one item, hold it until transferred, then maybe idle
    task automatic send_item(input t_map_item it);
        int unsigned gap;
        i_valid      <= 1'b1;
        i_kind       <= it.kind;
        i_byte_addr  <= it.addr;
        i_byte_value <= it.value;
        i_tile_x     <= it.x;
        i_tile_y     <= it.y;
        do @(posedge i_clk); while (o_stall);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waiting on a clock edge first lets the monitor log a query taken at the last edge
    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.expected_index.size() != 0) @(posedge i_clk);
    endtask

    // Empty the pipeline, writes included, before touching registers
    task automatic settle();
        drain_sink = 1'b1;
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // All four registers, then a write to an unused index that must be ignored
    task automatic apply_config(input logic [REG_W-1:0] frames, input logic [REG_W-1:0] w,
                                input logic [REG_W-1:0] h, input logic [REG_W-1:0] loaded);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [REG_W-1:0]     val [5];
        idx[0] = CFG_TILE_FRAMES;    val[0] = frames;
        idx[1] = CFG_MAP_WIDTH;      val[1] = w;
        idx[2] = CFG_MAP_HEIGHT;     val[2] = h;
        idx[3] = CFG_MAP_DATA_BYTES; val[3] = loaded;
        idx[4] = CFG_MAP_DATA_BYTES + CFG_IDX_W'($urandom_range(1, 252));
        val[4] = 8'($urandom);
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        drain_sink = 1'b0;
    endtask

    task automatic run_phase(input logic [REG_W-1:0] frames, input logic [REG_W-1:0] w,
                             input logic [REG_W-1:0] h, input logic [REG_W-1:0] loaded,
                             input int count, input t_phase_mode mode);
        settle();
        apply_config(frames, w, h, loaded);
        for (int i = 0; i < count; i++) begin
            if (i % 20 == 0) gap_free = ($urandom_range(0, 3) == 0);
            // back-to-back items against a long result hold
            if (mode == PHASE_SQUEEZE && i == 10) long_hold_req = 1'b1;
            if (mode == PHASE_SQUEEZE && i >= 10 && i < 50) gap_free = 1'b1;
            if (mode == PHASE_SQUEEZE && i == 50) gap_free = 1'b0;
            if (mode == PHASE_PAUSE && i == count / 2) wait_results();
            send_item(random_item(32'(w), 32'(h), 32'(loaded)));
        end
        gap_free = 1'b0;
    endtask

    initial begin
        tracker = new();
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_kind       <= KIND_WRITE;
        i_byte_addr  <= '0;
        i_byte_value <= '0;
        i_tile_x     <= '0;
        i_tile_y     <= '0;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= '0;
        i_cfg_data   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // load every store byte so later reads are always defined
        for (int a = 0; a < MAP_BYTES; a++) send_item(make_write(a, $urandom));

        // directed: one 4x8 page with known bytes, eleven frames
        settle();
        apply_config(FRAMES_ELEVEN, 8'd4, 8'd8, 8'd4);
        send_item(make_write(0, 8'h00));
        send_item(make_write(1, 8'hFF));
        send_item(make_write(2, 8'hA5));
        send_item(make_write(3, 8'hF0));
        send_item(make_query(0, 3));            // empty center
        send_item(make_query(1, 0));
        send_item(make_query(1, 4));
        send_item(make_query(1, 7));
        send_item(make_query(2, 0));
        send_item(make_query(3, 7));
        send_item(make_query(-1, 0));           // center off the map
        send_item(make_query(4, 3));
        send_item(make_query(0, 8));
        send_item(make_query(0, -1));
        send_item(make_query(32767, 32767));    // neighbors past 16-bit range
        send_item(make_query(-32768, -32768));
        send_item(make_query(32767, 0));
        send_item(make_query(-32768, 5));
        send_item(make_query(3, 3));

        // directed: two frames, second page partly past the loaded length
        settle();
        apply_config(FRAMES_TWO, 8'd4, 8'd16, 8'd6);
        send_item(make_query(1, 1));
        send_item(make_query(0, 0));
        send_item(make_query(2, 9));
        send_item(make_query(3, 12));
        send_item(make_query(1, 8));

        // random phases across geometries and frame counts
        run_phase(FRAMES_ELEVEN, 8'd16, 8'd16, 8'd32, PHASE_ITEMS, PHASE_PLAIN);
        run_phase(FRAMES_TWO, 8'd8, 8'd8, 8'd8, PHASE_ITEMS, PHASE_SQUEEZE);
        run_phase(8'd0, 8'd5, 8'd12, 8'd10, 20, PHASE_PLAIN);
        run_phase(FRAMES_ELEVEN, 8'd30, 8'd16, 8'd60, PHASE_ITEMS, PHASE_PAUSE);
        run_phase(8'd255, 8'd1, 8'd1, 8'd1, 15, PHASE_PLAIN);
        run_phase(FRAMES_ELEVEN, 8'd255, 8'd255, 8'd255, PHASE_ITEMS, PHASE_PLAIN);
        run_phase(FRAMES_TWO, 8'd1, 8'd255, 8'd255, 20, PHASE_PLAIN);
        run_phase(FRAMES_ELEVEN, 8'd255, 8'd1, 8'd255, 20, PHASE_PLAIN);
        run_phase(FRAMES_ELEVEN, 8'd12, 8'd20, 8'd0, 15, PHASE_PLAIN);
        run_phase(FRAMES_TWO, 8'd3, 8'd40, 8'd15, 25, PHASE_PLAIN);
        run_phase(FRAMES_ELEVEN, 8'd10, 8'd24, 8'd30, PHASE_ITEMS, PHASE_PLAIN);
        run_phase(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                  8'($urandom), PHASE_ITEMS, PHASE_PLAIN);

        settle();
        if (tracker.fail_count == 0 && tracker.expected_index.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* autotile_index_lookup_unit.f */
design/atil_pkg.sv
design/atil_ram.sv
design/autotile_index_lookup_unit.sv
bench/autotile_index_lookup_unit_tb.sv
